[src/utf8_stream_decoder_unit_defines.svh]
// assertion macros for the utf8 stream decoder unit
// no dependencies; included by files that carry concurrent checks
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define U8SD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define U8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define U8SD_ASSERT_NOW(lbl, ante, cons, msg)
`define U8SD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/utf8sd_pkg.sv]
// shared types and byte constants for the utf8 stream decoder
// no dependencies; imported by utf8sd_core, the top level and the testbench
package utf8sd_pkg;

  // lead byte class boundaries
  localparam logic [7:0] LEAD_ASCII_END = 8'h80;
  localparam logic [7:0] LEAD_2_MIN     = 8'hC2;
  localparam logic [7:0] LEAD_3_MIN     = 8'hE0;
  localparam logic [7:0] LEAD_4_MIN     = 8'hF0;
  localparam logic [7:0] LEAD_5_MIN     = 8'hF8;
  localparam logic [7:0] LEAD_6_MIN     = 8'hFC;
  localparam logic [7:0] LEAD_BAD_MIN   = 8'hFE;

  // continuation marker: top two bits must be 2'b10
  localparam logic [1:0] CONT_TAG = 2'b10;

  // smallest legal second byte after the leads that allow overlong forms
  localparam logic [7:0] MIN_AFTER_E0 = 8'hA0;
  localparam logic [7:0] MIN_AFTER_F0 = 8'h90;
  localparam logic [7:0] MIN_AFTER_F8 = 8'h88;
  localparam logic [7:0] MIN_AFTER_FC = 8'h84;

  localparam int unsigned CP_W  = 31;
  localparam int unsigned CNT_W = 3;

  typedef logic [CP_W-1:0]  cp_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // one decoded result
  typedef struct packed {
    logic valid;
    cp_t  code_point;
    logic is_error;
    logic string_done;
  } result_t;

  // decoder status seen by the top level
  typedef struct packed {
    logic discarding;
    cnt_t bytes_remaining;
    cnt_t seq_length;
  } status_t;

endpackage

[src/utf8sd_core.sv]
// decode step and sequence state for the utf8 stream decoder
// depends on utf8sd_pkg
module utf8sd_core
  import utf8sd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,        // consume one byte this cycle
  input  logic [7:0]    in_byte,
  input  logic          end_of_string,
  output result_t       res,         // result of the byte, valid with step
  output status_t       stat
);

  cp_t        partial_r,   partial_nxt;
  cnt_t       remain_r,    remain_nxt;
  cnt_t       len_r,       len_nxt;
  logic [7:0] lead_r,      lead_nxt;
  logic       discard_r,   discard_nxt;

  // one decode step over the current byte and state
  always_comb begin
    cp_t  cont_val;
    cnt_t dec_remain;
    logic overlong;
    logic fail;

    partial_nxt = partial_r;
    remain_nxt  = remain_r;
    len_nxt     = len_r;
    lead_nxt    = lead_r;
    discard_nxt = discard_r;
    res         = '0;
    fail        = 1'b0;
    overlong    = 1'b0;
    cont_val    = {partial_r[CP_W-7:0], in_byte[5:0]};
    dec_remain  = remain_r - cnt_t'(1);

    if (discard_r) begin
      // drop bytes up to the end of the string
      if (end_of_string) begin
        discard_nxt = 1'b0;
        partial_nxt = '0;
        remain_nxt  = '0;
        len_nxt     = '0;
        lead_nxt    = '0;
      end
    end else if (remain_r == '0) begin
      // lead byte
      priority if (in_byte < LEAD_ASCII_END) begin
        res.valid       = 1'b1;
        res.code_point  = cp_t'(in_byte);
        res.string_done = end_of_string;
      end else if (in_byte < LEAD_2_MIN) begin
        fail = 1'b1;
      end else if (in_byte >= LEAD_BAD_MIN) begin
        fail = 1'b1;
      end else if (end_of_string) begin
        fail = 1'b1;
      end else begin
        lead_nxt = in_byte;
        priority if (in_byte < LEAD_3_MIN) begin
          len_nxt     = cnt_t'(2);
          partial_nxt = cp_t'(in_byte[4:0]);
        end else if (in_byte < LEAD_4_MIN) begin
          len_nxt     = cnt_t'(3);
          partial_nxt = cp_t'(in_byte[3:0]);
        end else if (in_byte < LEAD_5_MIN) begin
          len_nxt     = cnt_t'(4);
          partial_nxt = cp_t'(in_byte[2:0]);
        end else if (in_byte < LEAD_6_MIN) begin
          len_nxt     = cnt_t'(5);
          partial_nxt = cp_t'(in_byte[1:0]);
        end else begin
          len_nxt     = cnt_t'(6);
          partial_nxt = cp_t'(in_byte[0]);
        end
        remain_nxt = len_nxt - cnt_t'(1);
      end
    end else begin
      // continuation byte, with the overlong test on the first one
      if (remain_r + cnt_t'(1) == len_r) begin
        overlong = (lead_r == LEAD_3_MIN && in_byte < MIN_AFTER_E0) ||
                   (lead_r == LEAD_4_MIN && in_byte < MIN_AFTER_F0) ||
                   (lead_r == LEAD_5_MIN && in_byte < MIN_AFTER_F8) ||
                   (lead_r == LEAD_6_MIN && in_byte < MIN_AFTER_FC);
      end
      priority if (in_byte[7:6] != CONT_TAG || overlong) begin
        fail = 1'b1;
      end else if (dec_remain == '0) begin
        res.valid       = 1'b1;
        res.code_point  = cont_val;
        res.string_done = end_of_string;
        partial_nxt     = '0;
        remain_nxt      = '0;
        len_nxt         = '0;
        lead_nxt        = '0;
      end else if (end_of_string) begin
        fail = 1'b1;
      end else begin
        partial_nxt = cont_val;
        remain_nxt  = dec_remain;
      end
    end

    // error result: clear the sequence, discard unless string is done
    if (fail) begin
      res.valid       = 1'b1;
      res.code_point  = '0;
      res.is_error    = 1'b1;
      res.string_done = end_of_string;
      partial_nxt     = '0;
      remain_nxt      = '0;
      len_nxt         = '0;
      lead_nxt        = '0;
      discard_nxt     = !end_of_string;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      remain_r  <= '0;
      len_r     <= '0;
      lead_r    <= '0;
      discard_r <= 1'b0;
    end else if (step) begin
      partial_r <= partial_nxt;
      remain_r  <= remain_nxt;
      len_r     <= len_nxt;
      lead_r    <= lead_nxt;
      discard_r <= discard_nxt;
    end
  end

  assign stat.discarding      = discard_r;
  assign stat.bytes_remaining = remain_r;
  assign stat.seq_length      = len_r;

endmodule

[src/utf8_stream_decoder_unit.sv]
// Streaming UTF-8 decoder (original six-byte form): one byte per input beat, tlast
// marking the final byte of a string; one result beat per completed code point or
// error. Throughput is one byte per clock while the output is not stalled, set by the
// single decode step that sits between the input register and the result register;
// a byte passes the input register, then the decode step into the result register.
// No clearing pass runs after reset; the block takes beats as soon as rst_n is released.
// depends on utf8sd_pkg, utf8sd_core and utf8_stream_decoder_unit_defines.svh
`include "utf8_stream_decoder_unit_defines.svh"

module utf8_stream_decoder_unit
  import utf8sd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,    // end_of_string
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [30:0] code_point, [31] zero
  output logic        out_tuser,   // is_error
  output logic        out_tlast    // string_done
);

  logic       in_v_r,    in_v_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_v_r,   out_v_nxt;
  cp_t        out_cp_r;
  logic       out_err_r;
  logic       out_done_r;
  logic       proc;
  result_t    res;
  status_t    stat;

  // a held byte is decoded once the result register can take its beat
  assign proc      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proc;

  // input register
  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (proc) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // decode step
  utf8sd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (proc),
    .in_byte       (in_byte_r),
    .end_of_string (in_last_r),
    .res           (res),
    .stat          (stat)
  );

  // result register
  always_comb begin
    out_v_nxt = out_v_r;
    if (proc && res.valid) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res.valid) begin
      out_cp_r   <= res.code_point;
      out_err_r  <= res.is_error;
      out_done_r <= res.string_done;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_cp_r};
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_done_r;

  // checks
  `U8SD_ASSERT_NOW(a_err_zero_cp, out_tvalid && out_tuser, out_tdata == 32'd0, "error beat with nonzero code point")
  `U8SD_ASSERT_NOW(a_discard_no_seq, stat.discarding, stat.bytes_remaining == '0, "discarding with an open sequence")
  `U8SD_ASSERT_NOW(a_remain_range, stat.bytes_remaining != '0, stat.bytes_remaining < stat.seq_length, "remaining count not below sequence length")
  `U8SD_ASSERT_NEXT(a_result_loaded, proc && res.valid, out_tvalid, "decoded result not presented")

endmodule

[dv/tb_utf8_stream_decoder_unit.sv]
// testbench for utf8_stream_decoder_unit: directed and random byte strings, a decode
// predictor kept in step with the input beats, and an in-order result check
// depends on utf8sd_pkg and the utf8_stream_decoder_unit rtl
module tb_utf8_stream_decoder_unit;
  import utf8sd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned REPORT_MAX     = 10;
  localparam int unsigned IDLE_PCT       = 7;
  localparam logic [7:0]  LEAD_2_PREFIX  = 8'hC0;
  localparam logic [7:0]  CONT_BASE      = 8'h80;

  typedef enum int {CH_VALID, CH_OVERLONG, CH_BAD_CONT, CH_BAD_LEAD} char_kind_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        in_tlast = 1'b0;    // end_of_string
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [30:0] code_point, [31] zero
  logic        out_tuser;          // is_error
  logic        out_tlast;          // string_done

  // decoder state mirrored by the predictor
  cp_t        dec_partial = '0;
  cnt_t       dec_left = '0;
  cnt_t       dec_len = '0;
  logic [7:0] dec_lead = 8'h00;
  logic       dec_dropping = 1'b0;

  result_t     pending_chars[$];
  logic [7:0]  str_bytes[$];
  int unsigned mismatch_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned stall_free_cycles = 0;
  bit          no_idle = 1'b0;

  utf8_stream_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_seq();
    dec_partial = '0;
    dec_left    = '0;
    dec_len     = '0;
    dec_lead    = 8'h00;
  endfunction

  // error result; the rest of the string is dropped unless this byte ends it
  function automatic void abort_string(input logic eos, output result_t r);
    clear_seq();
    dec_dropping  = !eos;
    r             = '0;
    r.valid       = 1'b1;
    r.is_error    = 1'b1;
    r.string_done = eos;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eos,
                                      output result_t r);
    logic [7:0] min_second;
    r = '0;
    min_second = 8'h00;
    if (dec_dropping) begin
      if (eos) begin
        dec_dropping = 1'b0;
        clear_seq();
      end
    end else if (dec_left == 0) begin
      // lead position
      if (b < LEAD_ASCII_END) begin
        r.valid       = 1'b1;
        r.code_point  = cp_t'(b);
        r.string_done = eos;
      end else if (b < LEAD_2_MIN || b >= LEAD_BAD_MIN || eos) begin
        abort_string(eos, r);
      end else begin
        dec_lead = b;
        if (b < LEAD_3_MIN) begin
          dec_len = 3'd2; dec_partial = cp_t'(b[4:0]);
        end else if (b < LEAD_4_MIN) begin
          dec_len = 3'd3; dec_partial = cp_t'(b[3:0]);
        end else if (b < LEAD_5_MIN) begin
          dec_len = 3'd4; dec_partial = cp_t'(b[2:0]);
        end else if (b < LEAD_6_MIN) begin
          dec_len = 3'd5; dec_partial = cp_t'(b[1:0]);
        end else begin
          dec_len = 3'd6; dec_partial = cp_t'(b[0]);
        end
        dec_left = dec_len - 3'd1;
      end
    end else if (b[7:6] != CONT_TAG) begin
      abort_string(eos, r);
    end else begin
      // overlong forms are caught on the first continuation byte only
      if (dec_left + 1 == dec_len) begin
        case (dec_lead)
          LEAD_3_MIN: min_second = MIN_AFTER_E0;
          LEAD_4_MIN: min_second = MIN_AFTER_F0;
          LEAD_5_MIN: min_second = MIN_AFTER_F8;
          LEAD_6_MIN: min_second = MIN_AFTER_FC;
          default:    min_second = 8'h00;
        endcase
      end
      if (b < min_second) begin
        abort_string(eos, r);
      end else begin
        dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
        dec_left    = dec_left - 3'd1;
        if (dec_left == 0) begin
          r.valid       = 1'b1;
          r.code_point  = dec_partial;
          r.string_done = eos;
          clear_seq();
        end else if (eos) begin
          abort_string(eos, r);
        end
      end
    end
  endfunction

  // ------------------------------------------------------------ result check

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                                out_tdata, out_tuser, out_tlast));
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== {1'b0, want.code_point} || out_tuser !== want.is_error ||
            out_tlast !== want.string_done)
          note_mismatch($sformatf(
            "result differs: exp cp=%h err=%b done=%b, got tdata=%h tuser=%b tlast=%b",
            want.code_point, want.is_error, want.string_done,
            out_tdata, out_tuser, out_tlast));
      end
    end
  end

  // watchdog: cycles in a row with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_free_cycles <= 0;
    else
      stall_free_cycles <= stall_free_cycles + 1;
    if (stall_free_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  // one input beat; tvalid stays high on exit so back-to-back beats need no gap
  task automatic send_byte(input logic [7:0] b, input logic eos);
    result_t r;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, eos, r);
    if (r.valid) pending_chars.push_back(r);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] lead_prefix(input int n);
    case (n)
      2:       return LEAD_2_PREFIX;
      3:       return LEAD_3_MIN;
      4:       return LEAD_4_MIN;
      5:       return LEAD_5_MIN;
      6:       return LEAD_6_MIN;
      default: return 8'h00;
    endcase
  endfunction

  // payload bits carried by a sequence of n bytes
  function automatic int cp_bits(input int n);
    return (n == 1) ? 7 : 5 * n + 1;
  endfunction

  // append one character of the given kind to str_bytes
  task automatic append_char(input char_kind_e kind);
    int          n;
    int          idx;
    logic [31:0] cp;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] chunk;
    logic [7:0]  seq[6];
    logic [7:0]  bad;
    logic [7:0]  min_second;
    case (kind)
      CH_OVERLONG: n = $urandom_range(3, 6);
      CH_BAD_CONT: n = $urandom_range(2, 6);
      default:     n = $urandom_range(1, 6);
    endcase
    lo = (n == 1) ? 32'd0 : (32'd1 << cp_bits(n - 1));
    hi = (32'd1 << cp_bits(n)) - 32'd1;
    cp = $urandom_range(hi, lo);
    for (int k = 0; k < n; k++) begin
      chunk = cp >> (6 * (n - 1 - k));
      seq[k] = (k == 0) ? (lead_prefix(n) | chunk[7:0]) : (CONT_BASE | {2'b00, chunk[5:0]});
    end
    case (kind)
      CH_OVERLONG: begin
        case (n)
          3:       min_second = MIN_AFTER_E0;
          4:       min_second = MIN_AFTER_F0;
          5:       min_second = MIN_AFTER_F8;
          default: min_second = MIN_AFTER_FC;
        endcase
        seq[0] = lead_prefix(n);
        seq[1] = 8'($urandom_range(min_second - 1, CONT_BASE));
      end
      CH_BAD_CONT: begin
        idx = $urandom_range(1, n - 1);
        do bad = 8'($urandom); while (bad[7:6] == CONT_TAG);
        seq[idx] = bad;
      end
      CH_BAD_LEAD: begin
        n = 1;
        seq[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(255, LEAD_BAD_MIN))
                                             : 8'($urandom_range(LEAD_2_MIN - 1, CONT_BASE));
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) str_bytes.push_back(seq[k]);
  endtask

  // strings of up to six characters, a few of them broken or cut short
  task automatic test_random_strings(input int unsigned n_items, input int unsigned bad_pct);
    int unsigned stop_at;
    int          n_chars;
    int          cut;
    char_kind_e  kind;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      str_bytes.delete();
      n_chars = $urandom_range(1, 6);
      for (int c = 0; c < n_chars; c++) begin
        if ($urandom_range(0, 99) < bad_pct)
          kind = char_kind_e'($urandom_range(CH_BAD_LEAD, CH_OVERLONG));
        else
          kind = CH_VALID;
        append_char(kind);
      end
      // truncated string: drop one to five bytes from the end of the string
      if ($urandom_range(0, 99) < bad_pct && str_bytes.size() > 1) begin
        cut = $urandom_range(1, (str_bytes.size() > 5) ? 5 : str_bytes.size() - 1);
        repeat (cut) void'(str_bytes.pop_back());
      end
      foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
    end
  endtask

  task automatic test_random_noise(input int unsigned n_items);
    repeat (n_items) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  task automatic test_directed();
    // ascii extremes, invalid leads at string end and mid-string with a dropped byte
    send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b1); send_byte(8'h80, 1'b1);
    send_byte(8'hC1, 1'b0); send_byte(8'h41, 1'b1);
    send_byte(8'hFE, 1'b1); send_byte(8'hFF, 1'b1);
    // smallest and largest two-byte values
    send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b1);
    send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b1);
    // overlong three-byte form mid-string, then the dropped end byte
    send_byte(8'hE0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h80, 1'b1);
    // string ending on a lead byte and inside a sequence
    send_byte(8'hC2, 1'b1);
    send_byte(8'hE0, 1'b0); send_byte(8'hA0, 1'b1);
    // bad continuation on the final byte
    send_byte(8'hC2, 1'b0); send_byte(8'h41, 1'b1);
    // overlong six-byte form
    send_byte(8'hFC, 1'b0); send_byte(8'h83, 1'b1);
    // largest code point
    send_byte(8'hFD, 1'b0);
    repeat (4) send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_no_stall_burst(input int unsigned n_items);
    no_idle = 1'b1;
    test_random_strings(n_items, 10);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_strings(700, 12);
    // sender holds off until every result is back
    wait_drained();
    test_no_stall_burst(300);
    test_random_noise(450);

    wait_drained();
    if (mismatch_cnt == 0 && pending_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
